@@ sv/sbt_pkg.sv @@
// Shared types, widths and constants of the Bezier servo trajectory block.
package sbt_pkg;

    // Frames per move.
    localparam int STEPS = 40;

    localparam int NJ    = 4;    // joints
    localparam int AW    = 12;   // angle width, sixteenths of a degree
    localparam int FW    = 6;    // frame index width
    localparam int OFW   = 8;    // calibration offset width
    localparam int MW    = 4;    // reverse mask width
    localparam int PLW   = 12;   // pulse width
    localparam int DATAW = 32;   // configuration data width

    // Configuration register map.
    localparam int NUM_REGS = 7;
    localparam int ADDR_W   = $clog2(NUM_REGS * 4);
    localparam int IDX_W    = ADDR_W - 2;

    localparam logic [IDX_W-1:0] REG_OFFSET0   = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_OFFSET1   = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_OFFSET2   = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_OFFSET3   = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_REVERSE   = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_PULSE_MIN = IDX_W'(5);
    localparam logic [IDX_W-1:0] REG_PULSE_MAX = IDX_W'(6);

    localparam logic [PLW-1:0] PULSE_MIN_RST = PLW'(102);
    localparam logic [PLW-1:0] PULSE_MAX_RST = PLW'(512);
    localparam int             PULSE_TOP     = 4095;

    // Curve arithmetic widths.
    localparam int UW  = $clog2(STEPS + 1);        // u = STEPS - k
    localparam int WW  = $clog2(STEPS ** 3 + 1);   // Bernstein weight sums
    localparam int DW  = WW + 1;                   // signed weight difference
    localparam int NW  = WW + 14;                  // scaled numerator
    localparam int QW  = NW - 1;                   // numerator magnitude

    // Control point bias: 10 degrees in sixteenths.
    localparam int CTRL_BIAS = 160;

    // Denominator 16 * STEPS^3 and its reciprocal scaled by 2^NW.
    localparam int    DEN   = 16 * STEPS ** 3;
    localparam int    RSH   = NW;
    localparam longint RECIP = (64'd1 << NW) / DEN;
    localparam int    RBW   = $clog2(RECIP + 1);

    localparam int XW  = 10;        // whole degrees, signed
    localparam int XMW = XW - 1;    // whole degree magnitude

    // Pulse mapping: pulse_min + (x + 90) * span / 180.
    localparam int DEG_HALF  = 90;
    localparam int DEG_RANGE = 180;
    localparam int SPW       = PLW + 1;            // signed span
    localparam int PW        = 24;                 // signed product
    localparam int AMW       = PW - 1;             // product magnitude
    localparam int M2SH      = 24;
    localparam longint M2    = (64'd1 << M2SH) / DEG_RANGE;
    localparam int M2W       = $clog2(M2 + 1);
    localparam int EW2       = 13;                 // quotient magnitude
    localparam int OUTW      = EW2 + 2;            // signed pulse before clamp

    // Lane pipeline stages from weights to pulse.
    localparam int LANE_STAGES = 7;

    typedef logic [NJ-1:0][AW-1:0] joint_vec_t;

    typedef struct packed {
        logic [NJ-1:0][OFW-1:0] offset;
        logic [MW-1:0]          reverse;
        logic [PLW-1:0]         pulse_min;
        logic [PLW-1:0]         pulse_max;
    } cfg_t;

    typedef struct packed {
        logic [FW-1:0] idx;
        logic          last;
    } tag_t;

    typedef struct packed {
        tag_t                  tag;
        logic [WW-1:0]         wa;   // u^3 + 3u^2k
        logic [WW-1:0]         wb;   // k^3 + 3uk^2
        logic signed [DW-1:0]  wd;   // 3uk(u - k)
        joint_vec_t            p0;
        joint_vec_t            p3;
    } frame_t;

endpackage

@@ sv/sbt_apb_regs.sv @@
// APB configuration registers: offsets, reverse mask and pulse limits.
module sbt_apb_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sbt_pkg::ADDR_W-1:0]  paddr,
    input  logic [sbt_pkg::DATAW-1:0]   pwdata,
    output logic [sbt_pkg::DATAW-1:0]   prdata,
    output logic                        pready,
    output sbt_pkg::cfg_t               cfg
);

    sbt_pkg::cfg_t cfg_reg;
    sbt_pkg::cfg_t cfg_next;

    logic                       wr_en;
    logic [sbt_pkg::IDX_W-1:0]  idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[sbt_pkg::ADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                sbt_pkg::REG_OFFSET0:   cfg_next.offset[0] = pwdata[sbt_pkg::OFW-1:0];
                sbt_pkg::REG_OFFSET1:   cfg_next.offset[1] = pwdata[sbt_pkg::OFW-1:0];
                sbt_pkg::REG_OFFSET2:   cfg_next.offset[2] = pwdata[sbt_pkg::OFW-1:0];
                sbt_pkg::REG_OFFSET3:   cfg_next.offset[3] = pwdata[sbt_pkg::OFW-1:0];
                sbt_pkg::REG_REVERSE:   cfg_next.reverse   = pwdata[sbt_pkg::MW-1:0];
                sbt_pkg::REG_PULSE_MIN: cfg_next.pulse_min = pwdata[sbt_pkg::PLW-1:0];
                sbt_pkg::REG_PULSE_MAX: cfg_next.pulse_max = pwdata[sbt_pkg::PLW-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.offset    <= '0;
            cfg_reg.reverse   <= '0;
            cfg_reg.pulse_min <= sbt_pkg::PULSE_MIN_RST;
            cfg_reg.pulse_max <= sbt_pkg::PULSE_MAX_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (idx)
            sbt_pkg::REG_OFFSET0: prdata = {{(sbt_pkg::DATAW-sbt_pkg::OFW){cfg_reg.offset[0][sbt_pkg::OFW-1]}},
                                            cfg_reg.offset[0]};
            sbt_pkg::REG_OFFSET1: prdata = {{(sbt_pkg::DATAW-sbt_pkg::OFW){cfg_reg.offset[1][sbt_pkg::OFW-1]}},
                                            cfg_reg.offset[1]};
            sbt_pkg::REG_OFFSET2: prdata = {{(sbt_pkg::DATAW-sbt_pkg::OFW){cfg_reg.offset[2][sbt_pkg::OFW-1]}},
                                            cfg_reg.offset[2]};
            sbt_pkg::REG_OFFSET3: prdata = {{(sbt_pkg::DATAW-sbt_pkg::OFW){cfg_reg.offset[3][sbt_pkg::OFW-1]}},
                                            cfg_reg.offset[3]};
            sbt_pkg::REG_REVERSE:   prdata = sbt_pkg::DATAW'(cfg_reg.reverse);
            sbt_pkg::REG_PULSE_MIN: prdata = sbt_pkg::DATAW'(cfg_reg.pulse_min);
            sbt_pkg::REG_PULSE_MAX: prdata = sbt_pkg::DATAW'(cfg_reg.pulse_max);
            default:                prdata = '0;
        endcase
    end

endmodule

@@ sv/sbt_frame_gen.sv @@
// Request holding, step counter and the two Bernstein weight stages.
module sbt_frame_gen (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sbt_pkg::joint_vec_t   start_angle,
    input  sbt_pkg::joint_vec_t   end_angle,
    output logic                  frame_valid,
    output sbt_pkg::frame_t       frame
);

    logic                          busy_reg;
    logic                          busy_next;
    logic [sbt_pkg::FW-1:0]        k_reg;
    logic [sbt_pkg::FW-1:0]        k_next;
    sbt_pkg::joint_vec_t           held_start_reg;
    sbt_pkg::joint_vec_t           held_end_reg;

    logic                          issue;
    logic                          last_k;
    logic                          accept;

    // Stage one: u, k and their products.
    logic                          s1_valid_reg;
    sbt_pkg::tag_t                 s1_tag_reg;
    logic [sbt_pkg::UW-1:0]        s1_u_reg;
    logic [sbt_pkg::UW-1:0]        s1_k_reg;
    logic [2*sbt_pkg::UW-1:0]      s1_uu_reg;
    logic [2*sbt_pkg::UW-1:0]      s1_kk_reg;
    logic [2*sbt_pkg::UW-1:0]      s1_uk_reg;
    sbt_pkg::joint_vec_t           s1_p0_reg;
    sbt_pkg::joint_vec_t           s1_p3_reg;
    logic [sbt_pkg::UW-1:0]        u_next;
    logic [sbt_pkg::UW-1:0]        kk_w;

    // Stage two: weights.
    logic                          frame_valid_reg;
    sbt_pkg::frame_t               frame_reg;
    sbt_pkg::frame_t               frame_next;

    assign last_k  = (k_reg == sbt_pkg::FW'(sbt_pkg::STEPS - 1));
    assign issue   = busy_reg & adv;
    assign s_ready = ~busy_reg | (adv & last_k);
    assign accept  = s_valid & s_ready;

    always_comb begin
        busy_next = busy_reg;
        k_next    = k_reg;
        if (accept) begin
            busy_next = 1'b1;
            k_next    = '0;
        end else if (issue) begin
            if (last_k) begin
                busy_next = 1'b0;
                k_next    = '0;
            end else begin
                k_next = k_reg + sbt_pkg::FW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end else begin
            busy_reg <= busy_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            held_start_reg <= start_angle;
            held_end_reg   <= end_angle;
        end
    end

    assign kk_w   = sbt_pkg::UW'(k_reg);
    assign u_next = sbt_pkg::UW'(sbt_pkg::STEPS) - kk_w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg    <= 1'b0;
            frame_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg    <= issue;
            frame_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_tag_reg.idx  <= k_reg;
            s1_tag_reg.last <= last_k;
            s1_u_reg        <= u_next;
            s1_k_reg        <= kk_w;
            s1_uu_reg       <= (2*sbt_pkg::UW)'(u_next) * (2*sbt_pkg::UW)'(u_next);
            s1_kk_reg       <= (2*sbt_pkg::UW)'(kk_w) * (2*sbt_pkg::UW)'(kk_w);
            s1_uk_reg       <= (2*sbt_pkg::UW)'(u_next) * (2*sbt_pkg::UW)'(kk_w);
            s1_p0_reg       <= held_start_reg;
            s1_p3_reg       <= held_end_reg;
            frame_reg       <= frame_next;
        end
    end

    always_comb begin
        frame_next.tag = s1_tag_reg;
        frame_next.wa  = sbt_pkg::WW'(s1_uu_reg)
                       * (sbt_pkg::WW'(s1_u_reg) + sbt_pkg::WW'(s1_k_reg) * sbt_pkg::WW'(3));
        frame_next.wb  = sbt_pkg::WW'(s1_kk_reg)
                       * (sbt_pkg::WW'(s1_u_reg) * sbt_pkg::WW'(3) + sbt_pkg::WW'(s1_k_reg));
        frame_next.wd  = signed'(sbt_pkg::DW'(s1_uk_reg))
                       * (signed'(sbt_pkg::DW'(s1_u_reg)) - signed'(sbt_pkg::DW'(s1_k_reg)))
                       * signed'(sbt_pkg::DW'(3));
        frame_next.p0  = s1_p0_reg;
        frame_next.p3  = s1_p3_reg;
    end

    assign frame_valid = frame_valid_reg;
    assign frame       = frame_reg;

`ifndef SYNTHESIS
    a_accept_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && busy_reg) |-> (adv && last_k))
        else $error("request taken while a move is still issuing frames");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (k_reg <= sbt_pkg::FW'(sbt_pkg::STEPS - 1)))
        else $error("step counter beyond last frame");

    a_move_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (busy_reg && k_reg == '0))
        else $error("move did not start at frame zero");

    a_move_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && adv && last_k && !s_valid) |=> !busy_reg)
        else $error("move kept issuing after its last frame");
`endif

endmodule

@@ sv/sbt_joint_lane.sv @@
// One joint: curve numerator, exact division to degrees, pulse map and clamp.
module sbt_joint_lane (
    input  logic                              aclk,
    input  logic                              adv,
    input  logic [sbt_pkg::WW-1:0]            wa,
    input  logic [sbt_pkg::WW-1:0]            wb,
    input  logic signed [sbt_pkg::DW-1:0]     wd,
    input  logic signed [sbt_pkg::AW-1:0]     p0,
    input  logic signed [sbt_pkg::AW-1:0]     p3,
    input  logic signed [sbt_pkg::OFW-1:0]    offset,
    input  logic                              reverse,
    input  logic [sbt_pkg::PLW-1:0]           pulse_min,
    input  logic [sbt_pkg::PLW-1:0]           pulse_max,
    output logic [sbt_pkg::PLW-1:0]           pulse
);

    localparam int NW  = sbt_pkg::NW;
    localparam int QW  = sbt_pkg::QW;
    localparam int XW  = sbt_pkg::XW;
    localparam int XMW = sbt_pkg::XMW;
    localparam int PW  = sbt_pkg::PW;
    localparam int AMW = sbt_pkg::AMW;
    localparam int EW2 = sbt_pkg::EW2;
    localparam int SPW = sbt_pkg::SPW;
    localparam int OUTW = sbt_pkg::OUTW;
    localparam int RPW = QW + sbt_pkg::RBW;
    localparam int M2PW = AMW + sbt_pkg::M2W;
    localparam int PLW_W = sbt_pkg::PLW;

    // Stage one: products.
    logic signed [NW-1:0]   pa_reg, pb_reg, pc_reg, po_reg;
    logic signed [NW-1:0]   wa_s, wb_s, wd_s, p0_s, p3_s, off_s;
    // Stage two: signed numerator.
    logic signed [NW-1:0]   num_reg;
    logic signed [NW-1:0]   sum_w;
    // Stage three: magnitude and quotient estimate.
    logic                   neg_reg;
    logic [QW-1:0]          q_reg;
    logic [XMW-1:0]         est_reg;
    logic [QW-1:0]          q_w;
    logic [RPW-1:0]         rp_w;
    // Stage four: whole degrees.
    logic signed [XW-1:0]   x_reg;
    logic [QW-1:0]          rem_w;
    logic [XMW-1:0]         xm_w;
    // Stage five: scaled span.
    logic signed [PW-1:0]   prod_reg;
    logic signed [XW:0]     xb_w;
    logic signed [SPW-1:0]  span_w;
    // Stage six: magnitude and quotient estimate.
    logic                   neg2_reg;
    logic [AMW-1:0]         a_reg;
    logic [EW2-1:0]         est2_reg;
    logic [AMW-1:0]         a_w;
    logic [M2PW-1:0]        m2p_w;
    // Stage seven: pulse.
    logic [PLW_W-1:0]       pulse_reg;
    logic [AMW-1:0]         rem2_w;
    logic [EW2:0]           d_w;
    logic signed [OUTW-1:0] p_w;

    assign wa_s  = signed'(NW'(wa));
    assign wb_s  = signed'(NW'(wb));
    assign wd_s  = NW'(wd);
    assign p0_s  = NW'(p0);
    assign p3_s  = NW'(p3);
    assign off_s = NW'(offset);

    assign sum_w = pa_reg + pb_reg + pc_reg;

    assign q_w   = neg_w_calc(num_reg);
    assign rp_w  = RPW'(q_w) * RPW'(sbt_pkg::RECIP);

    // Estimate is floor or one below; fix with one compare.
    assign rem_w = q_reg - QW'(est_reg) * QW'(sbt_pkg::DEN);
    assign xm_w  = (rem_w >= QW'(sbt_pkg::DEN)) ? est_reg + XMW'(1) : est_reg;

    assign xb_w   = (XW+1)'(x_reg) + (XW+1)'(sbt_pkg::DEG_HALF);
    assign span_w = signed'(SPW'(pulse_max)) - signed'(SPW'(pulse_min));

    assign a_w   = prod_reg[PW-1] ? AMW'(-prod_reg) : AMW'(prod_reg);
    assign m2p_w = M2PW'(a_w) * M2PW'(sbt_pkg::M2);

    assign rem2_w = a_reg - AMW'(est2_reg) * AMW'(sbt_pkg::DEG_RANGE);
    assign d_w    = (rem2_w >= AMW'(sbt_pkg::DEG_RANGE)) ? (EW2+1)'(est2_reg) + (EW2+1)'(1)
                                                         : (EW2+1)'(est2_reg);
    assign p_w    = (neg2_reg ? -signed'(OUTW'(d_w)) : signed'(OUTW'(d_w)))
                  + signed'(OUTW'(pulse_min));

    function automatic logic [QW-1:0] neg_w_calc(input logic signed [NW-1:0] v);
        logic signed [NW-1:0] m;
        m = v[NW-1] ? -v : v;
        return m[QW-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (adv) begin
            pa_reg   <= wa_s * p0_s;
            pb_reg   <= wb_s * p3_s;
            pc_reg   <= wd_s * NW'(sbt_pkg::CTRL_BIAS);
            po_reg   <= off_s * NW'(sbt_pkg::DEN);

            num_reg  <= (reverse ? -sum_w : sum_w) + po_reg;

            neg_reg  <= num_reg[NW-1];
            q_reg    <= q_w;
            est_reg  <= rp_w[sbt_pkg::RSH +: XMW];

            x_reg    <= neg_reg ? -signed'(XW'(xm_w)) : signed'(XW'(xm_w));

            prod_reg <= PW'(xb_w) * PW'(span_w);

            neg2_reg <= prod_reg[PW-1];
            a_reg    <= a_w;
            est2_reg <= m2p_w[sbt_pkg::M2SH +: EW2];

            // Clamp to the PWM counter range.
            if (p_w < 0) begin
                pulse_reg <= '0;
            end else if (p_w > OUTW'(sbt_pkg::PULSE_TOP)) begin
                pulse_reg <= PLW_W'(sbt_pkg::PULSE_TOP);
            end else begin
                pulse_reg <= p_w[PLW_W-1:0];
            end
        end
    end

    assign pulse = pulse_reg;

endmodule

@@ sv/servo_bezier_trajectory_top.sv @@
// Top level of the four-joint cubic Bezier servo trajectory generator.
//
// Usage:
//   Each request on the s_ channel carries start and end angles for four
//   joints in sixteenths of a degree. It expands into STEPS (40) frames on
//   the m_ channel, frame_index 0..STEPS-1, last_frame set on the final one;
//   the end point itself is not sent. Each frame holds one 12-bit PWM count
//   per joint, clamped to 0..4095.
//   Throughput: one frame per cycle unless m_ready stalls; the next request
//   is taken in the cycle the last frame of the current move is issued, so
//   moves run back to back with no gap. The first frame of a request passes
//   the step counter, the two weight stages and the seven joint lane stages
//   before it appears. The whole pipeline advances when the output register
//   is empty or taken: a stall on m_ready freezes every stage, nothing is
//   lost or repeated. The user must send configuration through the APB
//   port only while no move is in flight; the block does not enforce it.
//   Reset (aresetn low, synchronous) empties the pipeline and loads the
//   register defaults: offsets 0, no reversal, pulse range 102..512.
module servo_bezier_trajectory_top (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [11:0]          s_start_angle0,
    input  logic signed [11:0]          s_start_angle1,
    input  logic signed [11:0]          s_start_angle2,
    input  logic signed [11:0]          s_start_angle3,
    input  logic signed [11:0]          s_end_angle0,
    input  logic signed [11:0]          s_end_angle1,
    input  logic signed [11:0]          s_end_angle2,
    input  logic signed [11:0]          s_end_angle3,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [5:0]                  m_frame_index,
    output logic [11:0]                 m_pulse0,
    output logic [11:0]                 m_pulse1,
    output logic [11:0]                 m_pulse2,
    output logic [11:0]                 m_pulse3,
    output logic                        m_last_frame,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sbt_pkg::ADDR_W-1:0]  paddr,
    input  logic [sbt_pkg::DATAW-1:0]   pwdata,
    output logic [sbt_pkg::DATAW-1:0]   prdata,
    output logic                        pready
);

    localparam int LS = sbt_pkg::LANE_STAGES;

    sbt_pkg::cfg_t          cfg;
    sbt_pkg::joint_vec_t    start_angle;
    sbt_pkg::joint_vec_t    end_angle;
    logic                   frame_valid;
    sbt_pkg::frame_t        frame;
    logic                   adv;

    logic                   vline_reg [LS];
    sbt_pkg::tag_t          tline_reg [LS];
    logic [sbt_pkg::PLW-1:0] pulse [sbt_pkg::NJ];

    assign start_angle = {s_start_angle3, s_start_angle2, s_start_angle1, s_start_angle0};
    assign end_angle   = {s_end_angle3, s_end_angle2, s_end_angle1, s_end_angle0};

    // Advance everything unless the output holds a frame nobody takes.
    assign adv = ~vline_reg[LS-1] | m_ready;

    sbt_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sbt_frame_gen u_gen (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .start_angle (start_angle),
        .end_angle   (end_angle),
        .frame_valid (frame_valid),
        .frame       (frame)
    );

    for (genvar j = 0; j < sbt_pkg::NJ; j++) begin : g_lane
        sbt_joint_lane u_lane (
            .aclk      (aclk),
            .adv       (adv),
            .wa        (frame.wa),
            .wb        (frame.wb),
            .wd        (frame.wd),
            .p0        (signed'(frame.p0[j])),
            .p3        (signed'(frame.p3[j])),
            .offset    (signed'(cfg.offset[j])),
            .reverse   (cfg.reverse[j]),
            .pulse_min (cfg.pulse_min),
            .pulse_max (cfg.pulse_max),
            .pulse     (pulse[j])
        );
    end

    // Carry valid, index and last flag alongside the lanes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LS; i++) begin
                vline_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            vline_reg[0] <= frame_valid;
            for (int i = 1; i < LS; i++) begin
                vline_reg[i] <= vline_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tline_reg[0] <= frame.tag;
            for (int i = 1; i < LS; i++) begin
                tline_reg[i] <= tline_reg[i-1];
            end
        end
    end

    assign m_valid       = vline_reg[LS-1];
    assign m_frame_index = tline_reg[LS-1].idx;
    assign m_last_frame  = tline_reg[LS-1].last;
    assign m_pulse0      = pulse[0];
    assign m_pulse1      = pulse[1];
    assign m_pulse2      = pulse[2];
    assign m_pulse3      = pulse[3];

endmodule
